@@ src/pmf_pkg.sv @@
// Shared constants, types and controller/datapath command structs of the profile median filter.
package pmf_pkg;

  localparam int MAX_HALF   = 7;
  localparam int COORD_BITS = 24;
  localparam int DEPTH      = 2 * MAX_HALF + 1;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int HALF_W     = 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [IDX_W-1:0]             idx_t;
  typedef logic [CNT_W-1:0]             cnt_t;
  typedef logic [HALF_W-1:0]            half_t;

  localparam half_t HALF_RESET = 3'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic shift;
    logic count;
    logic rank;
    logic load;
    logic use_med;
    logic run_last;
    logic profile_last;
    idx_t idx;
    idx_t half;
  } pmf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } pmf_status_t;

endpackage

@@ src/pmf_if.sv @@
// Stream interfaces for profile points in and filtered points out.
interface pmf_in_if;
  import pmf_pkg::*;
  logic   valid;
  logic   ready;
  coord_t x_in;
  coord_t z_in;
  logic   valid_in;
  logic   profile_end;

  modport source (output valid, x_in, z_in, valid_in, profile_end, input ready);
  modport sink   (input valid, x_in, z_in, valid_in, profile_end, output ready);
endinterface

interface pmf_out_if;
  import pmf_pkg::*;
  logic   valid;
  logic   ready;
  coord_t x_out;
  coord_t z_out;
  logic   valid_out;
  logic   run_last;
  logic   profile_last;

  modport source (output valid, x_out, z_out, valid_out, run_last, profile_last, input ready);
  modport sink   (input valid, x_out, z_out, valid_out, run_last, profile_last, output ready);
endinterface

@@ src/pmf_datapath.sv @@
// Datapath: point window shift register, rank unit, median registers and output register.
module pmf_datapath (
  input  logic                clk,
  input  logic                rst,
  input  pmf_pkg::coord_t     x_in,
  input  pmf_pkg::coord_t     z_in,
  input  logic                valid_in,
  input  pmf_pkg::pmf_cmd_t   cmd,
  output pmf_pkg::pmf_status_t status,
  output logic                out_valid,
  input  logic                out_ready,
  output pmf_pkg::coord_t     x_out,
  output pmf_pkg::coord_t     z_out,
  output logic                valid_out,
  output logic                run_last,
  output logic                profile_last
);
  import pmf_pkg::*;

  coord_t               wx [DEPTH];
  coord_t               wz [DEPTH];
  logic [DEPTH-1:0]     wv;
  logic [DEPTH-1:0]     win;
  logic [DEPTH-1:0]     less;
  idx_t                 twice_h;
  coord_t               cand_x;
  coord_t               cand_z;
  logic                 cand_v;
  cnt_t                 n_now;
  cnt_t                 rank;
  cnt_t                 n_reg;
  cnt_t                 lo_rank;
  cnt_t                 hi_rank;
  coord_t               lo_z;
  coord_t               hi_z;
  logic signed [COORD_BITS:0] mid_sum;
  coord_t               median;

  // Window shift register, newest point in entry 0.
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      for (int j = DEPTH - 1; j > 0; j--) begin
        wx[j] <= wx[j-1];
        wz[j] <= wz[j-1];
      end
      wx[0] <= x_in;
      wz[0] <= z_in;
      wv    <= {wv[DEPTH-2:0], valid_in};
    end
  end

  always_comb begin
    twice_h = idx_t'(cmd.half << 1);
    cand_x  = wx[cmd.idx];
    cand_z  = wz[cmd.idx];
    cand_v  = wv[cmd.idx];
    for (int j = 0; j < DEPTH; j++) begin
      win[j]  = wv[j] && (idx_t'(j) <= twice_h);
      less[j] = win[j] && ((wz[j] < cand_z) ||
                           ((wz[j] == cand_z) && (idx_t'(j) < cmd.idx)));
    end
  end

  // Valid count and stable rank of the candidate entry.
  always_comb begin
    n_now = '0;
    rank  = '0;
    for (int j = 0; j < DEPTH; j++) begin
      n_now = n_now + cnt_t'(win[j]);
      rank  = rank + cnt_t'(less[j]);
    end
  end

  assign lo_rank = (n_reg - 1'b1) >> 1;
  assign hi_rank = n_reg >> 1;
  assign mid_sum = {lo_z[COORD_BITS-1], lo_z} + {hi_z[COORD_BITS-1], hi_z};
  assign median  = mid_sum[COORD_BITS:1];

  always_ff @(posedge clk) begin
    if (cmd.count) begin
      n_reg <= n_now;
    end
    if (cmd.rank && cand_v) begin
      if (rank == lo_rank) begin
        lo_z <= cand_z;
      end
      if (rank == hi_rank) begin
        hi_z <= cand_z;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_out        <= cand_x;
      z_out        <= (cmd.use_med && (n_reg != '0)) ? median : cand_z;
      valid_out    <= cand_v;
      run_last     <= cmd.run_last;
      profile_last <= cmd.profile_last;
    end
  end

  assign status.out_free = !out_valid || out_ready;

endmodule

@@ src/pmf_ctrl.sv @@
// Controller: sequences window update, rank pass and emission of result points.
module pmf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_profile_end,
  output logic                 in_ready,
  input  logic                 cfg_we,
  input  pmf_pkg::half_t       cfg_data,
  output pmf_pkg::pmf_cmd_t    cmd,
  input  pmf_pkg::pmf_status_t status
);
  import pmf_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_COUNT, S_RANK, S_CENTER, S_FLUSH} state_t;

  state_t state;
  half_t  half_width;
  cnt_t   points_seen;
  idx_t   k;
  logic   end_lat;
  logic   use_med;
  idx_t   h;
  idx_t   twice_h;
  logic   accept;
  cnt_t   seen_next;

  always_comb begin
    h         = (int'(half_width) > MAX_HALF) ? idx_t'(MAX_HALF) : idx_t'(half_width);
    twice_h   = idx_t'(h << 1);
    in_ready  = (state == S_IDLE);
    accept    = in_valid && in_ready;
    seen_next = in_profile_end ? '0 :
                (points_seen < cnt_t'(DEPTH)) ? points_seen + 1'b1 : cnt_t'(DEPTH);
  end

  always_comb begin
    cmd         = '0;
    cmd.shift   = accept;
    cmd.half    = h;
    unique case (state)
      S_IDLE: begin
      end
      S_COUNT: begin
        cmd.count = 1'b1;
      end
      S_RANK: begin
        cmd.rank = 1'b1;
        cmd.idx  = k;
      end
      S_CENTER: begin
        cmd.idx          = h;
        cmd.use_med      = use_med;
        cmd.load         = status.out_free;
        cmd.run_last     = !(end_lat && (h != '0));
        cmd.profile_last = end_lat && (h == '0);
      end
      S_FLUSH: begin
        cmd.idx          = k;
        cmd.load         = status.out_free;
        cmd.run_last     = (k == '0);
        cmd.profile_last = (k == '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      half_width  <= HALF_RESET;
      points_seen <= '0;
      k           <= '0;
      end_lat     <= 1'b0;
      use_med     <= 1'b0;
    end else begin
      if (cfg_we) begin
        half_width <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            points_seen <= seen_next;
            end_lat     <= in_profile_end;
            k           <= '0;
            use_med     <= 1'b0;
            if (points_seen >= cnt_t'(twice_h)) begin
              state   <= S_COUNT;
              use_med <= 1'b1;
            end else if (points_seen >= cnt_t'(h)) begin
              state <= S_CENTER;
            end else if (in_profile_end) begin
              state <= S_FLUSH;
              k     <= idx_t'(points_seen);
            end
          end
        end
        S_COUNT: begin
          state <= S_RANK;
        end
        S_RANK: begin
          if (k == twice_h) begin
            state <= S_CENTER;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_CENTER: begin
          if (status.out_free) begin
            if (end_lat && (h != '0)) begin
              state <= S_FLUSH;
              k     <= h - 1'b1;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_FLUSH: begin
          if (status.out_free) begin
            if (k == '0) begin
              state <= S_IDLE;
            end else begin
              k <= k - 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> status.out_free)
    else $error("result loaded while the output register is still occupied");

  a_profile_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && in_profile_end) |=> (points_seen == '0))
    else $error("point count not cleared after the last point of a profile");

  a_rank_in_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_RANK) |-> (k <= twice_h))
    else $error("rank pass ran beyond the window");

  a_seen_saturates: assert property (@(posedge clk) disable iff (rst)
    points_seen <= cnt_t'(DEPTH))
    else $error("point count exceeded the window depth");

endmodule

@@ src/profile_masked_median_filter.sv @@
// Top level of the masked sliding-window median filter for laser line profiles.
// Points of one line profile arrive on the points channel, one transfer each, and
// filtered points leave on the results channel delayed by h points, where h is
// the half_width register (reset value 2). Each emitted point carries its own x
// and valid flag; its z is the median of the valid z values among the 2h+1 points
// centred on it, the floor of the mean of the two middle values for an even
// count, or the original z when no point of the window is valid. The first and
// last h points of a profile pass unchanged, and the point marked profile_end
// flushes the remaining h points, so that transfer can cause up to h+1 results;
// run_last marks the last result of each input point and profile_last the last
// point of the profile. The block works on one point at a time: a point is
// taken in, then the valid window entries are counted, then a rank pass steps
// through the 2h+1 window entries (one candidate entry ranked against all
// entries in parallel per cycle), and a final step loads the output register.
// Each of the first h points of a profile is only taken in, each of the next h
// points is taken in and loaded without counting or rank pass, and each flushed
// point adds a load of its own; every load waits while the results channel
// stalls. A finished result waits in the output register while the next point
// is already taken in. Write half_width only while the block is idle; a change
// inside a profile applies from the next point on.
module profile_masked_median_filter (
  input  logic           clk,
  input  logic           rst,
  pmf_in_if.sink         points,
  pmf_out_if.source      results,
  input  logic           cfg_we,
  input  pmf_pkg::half_t cfg_data
);
  import pmf_pkg::*;

  pmf_cmd_t    cmd;
  pmf_status_t status;
  logic        in_ready;

  // The controller owns the handshake on the input side and the point count.
  pmf_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (points.valid),
    .in_profile_end (points.profile_end),
    .in_ready       (in_ready),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .status         (status)
  );

  assign points.ready = in_ready;

  // The datapath holds the window, the rank unit and the output register.
  pmf_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .x_in         (points.x_in),
    .z_in         (points.z_in),
    .valid_in     (points.valid_in),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .x_out        (results.x_out),
    .z_out        (results.z_out),
    .valid_out    (results.valid_out),
    .run_last     (results.run_last),
    .profile_last (results.profile_last)
  );

endmodule

@@ dv/pmf_filter_checker.sv @@
// Scoreboard that predicts the filtered profile points and checks the results channel.
`timescale 1ns / 1ps
module pmf_filter_checker
  import pmf_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   cfg_we,
  input  half_t  cfg_data,
  input  logic   pt_valid,
  input  logic   pt_ready,
  input  coord_t pt_x,
  input  coord_t pt_z,
  input  logic   pt_flag,
  input  logic   pt_end,
  input  logic   res_valid,
  input  logic   res_ready,
  input  coord_t res_x,
  input  coord_t res_z,
  input  logic   res_flag,
  input  logic   res_run_last,
  input  logic   res_profile_last,
  output int     pending_points,
  output int     mismatches
);

  typedef struct {
    coord_t x;
    coord_t z;
    logic   flag;
  } profile_pt_t;

  typedef struct {
    coord_t x;
    coord_t z;
    logic   flag;
    logic   run_last;
    logic   profile_last;
  } filtered_pt_t;

  profile_pt_t  window [DEPTH];
  int           points_in_profile = 0;
  int           half_width = HALF_RESET;
  int           errs = 0;
  filtered_pt_t expected_points [$];
  filtered_pt_t want;

  // Median of the valid heights among window entries 0..2h; returns 0 for an empty window.
  function automatic logic window_median(input int h, output coord_t med);
    int vals [DEPTH];
    int n;
    int j;
    int t;
    int mid_sum;
    n   = 0;
    med = '0;
    for (int k = 0; k <= 2 * h && k < DEPTH; k++) begin
      if (window[k].flag) begin
        t = window[k].z;
        j = n;
        while (j > 0 && vals[j-1] > t) begin
          vals[j] = vals[j-1];
          j--;
        end
        vals[j] = t;
        n++;
      end
    end
    if (n == 0) return 1'b0;
    if (n % 2 == 1) begin
      mid_sum = vals[n/2];
    end else begin
      // Arithmetic shift floors the mean of the two middle values.
      mid_sum = (vals[n/2-1] + vals[n/2]) >>> 1;
    end
    med = mid_sum[COORD_BITS-1:0];
    return 1'b1;
  endfunction

  task automatic predict_filtered(input coord_t x, input coord_t z, input logic flag,
                                  input logic last);
    filtered_pt_t outs [MAX_HALF+1];
    int           h;
    int           seen;
    int           first;
    int           n;
    coord_t       zf;
    coord_t       med;
    h    = (half_width > MAX_HALF) ? MAX_HALF : half_width;
    seen = points_in_profile;
    n    = 0;
    for (int k = DEPTH - 1; k > 0; k--) window[k] = window[k-1];
    window[0].x    = x;
    window[0].z    = z;
    window[0].flag = flag;

    if (seen >= h) begin
      zf = window[h].z;
      if (seen >= 2 * h) begin
        if (window_median(h, med)) zf = med;
      end
      outs[n].x    = window[h].x;
      outs[n].z    = zf;
      outs[n].flag = window[h].flag;
      n++;
      first = h - 1;
    end else begin
      first = seen;
    end

    if (last) begin
      for (int k = first; k >= 0; k--) begin
        outs[n].x    = window[k].x;
        outs[n].z    = window[k].z;
        outs[n].flag = window[k].flag;
        n++;
      end
      points_in_profile = 0;
    end else begin
      points_in_profile = (seen < DEPTH) ? seen + 1 : DEPTH;
    end

    for (int k = 0; k < n; k++) begin
      outs[k].run_last     = (k == n - 1);
      outs[k].profile_last = last && (k == n - 1);
      expected_points.insert(expected_points.size(), outs[k]);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      points_in_profile = 0;
      half_width        = HALF_RESET;
      expected_points.delete();
    end else begin
      if (cfg_we) half_width = cfg_data;
      if (pt_valid && pt_ready) predict_filtered(pt_x, pt_z, pt_flag, pt_end);
      if (res_valid && res_ready) begin
        if (expected_points.size() == 0) begin
          $error("unexpected result: x_out %0d z_out %0d", res_x, res_z);
          errs++;
        end else begin
          want = expected_points.pop_front();
          if (res_x !== want.x) begin
            $error("x_out: expected %0d, got %0d", want.x, res_x);
            errs++;
          end
          if (res_z !== want.z) begin
            $error("z_out: expected %0d, got %0d", want.z, res_z);
            errs++;
          end
          if (res_flag !== want.flag) begin
            $error("valid_out: expected %0d, got %0d", want.flag, res_flag);
            errs++;
          end
          if (res_run_last !== want.run_last) begin
            $error("run_last: expected %0d, got %0d", want.run_last, res_run_last);
            errs++;
          end
          if (res_profile_last !== want.profile_last) begin
            $error("profile_last: expected %0d, got %0d", want.profile_last,
                   res_profile_last);
            errs++;
          end
        end
      end
    end
    pending_points <= expected_points.size();
    mismatches     <= errs;
  end

endmodule

@@ dv/tb_profile_masked_median_filter.sv @@
// Testbench top for the profile median filter: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_profile_masked_median_filter;
  import pmf_pkg::*;

  // A point inside a profile runs through intake, count, rank pass and load, plus a load
  // per flushed point, so the settle wait is plenty for a point with no result to finish.
  localparam int SETTLE_CYCLES   = 64;
  // Longest quiet span in a correct run is the long results hold-off plus a settle
  // pause, well under this limit.
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int HOLD_CYCLES     = 300;
  localparam int POINTS_PER_PASS = 16;

  localparam coord_t X_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam coord_t X_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

  logic  clk;
  logic  rst;
  logic  cfg_we;
  half_t cfg_data;
  int    src_idle_pct  = 30;
  int    sink_idle_pct = 64;
  logic  long_hold     = 1'b0;
  logic  hold_done     = 1'b0;
  int    pending_points;
  int    mismatches;
  int    quiet_cycles  = 0;

  pmf_in_if  pts ();
  pmf_out_if res ();

  profile_masked_median_filter u_top (
    .clk      (clk),
    .rst      (rst),
    .points   (pts),
    .results  (res),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  pmf_filter_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .pt_valid         (pts.valid),
    .pt_ready         (pts.ready),
    .pt_x             (pts.x_in),
    .pt_z             (pts.z_in),
    .pt_flag          (pts.valid_in),
    .pt_end           (pts.profile_end),
    .res_valid        (res.valid),
    .res_ready        (res.ready),
    .res_x            (res.x_out),
    .res_z            (res.z_out),
    .res_flag         (res.valid_out),
    .res_run_last     (res.run_last),
    .res_profile_last (res.profile_last),
    .pending_points   (pending_points),
    .mismatches       (mismatches)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Results side. Each cycle ready is dropped with the current idle percentage. When
  // the stimulus asks for a long hold-off, ready stays low for the HOLD_CYCLES span,
  // counted here, so the block fills up and has to stall the points channel.
  initial begin
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold && !hold_done) begin
        res.ready <= 1'b0;
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      res.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // Watchdog: ends the run if no transfer happens on either channel for too long.
  always @(posedge clk) begin
    if (rst || (pts.valid && pts.ready) || (res.valid && res.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one point and returns in the time step of the edge that takes it. Gap
  // cycles come before the point, so valid is only lowered when a gap really occurs
  // and stays high between back-to-back transfers.
  task automatic send_point(input coord_t x, input coord_t z, input logic flag,
                            input logic last);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      pts.valid <= 1'b0;
      @(posedge clk);
    end
    pts.valid       <= 1'b1;
    pts.x_in        <= x;
    pts.z_in        <= z;
    pts.valid_in    <= flag;
    pts.profile_end <= last;
    do @(posedge clk); while (!pts.ready);
  endtask

  // Stops offering points until every predicted result has arrived, then gives the
  // block time to finish any point that produces no result of its own.
  task automatic wait_drained();
    pts.valid <= 1'b0;
    do @(posedge clk); while (pending_points != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_half(input half_t h);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_data <= h;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Sends one whole profile. A z span of zero draws heights over the full range;
  // otherwise heights cluster around zero so that ties and close values are common.
  task automatic send_profile(input int len, input int zspan, input int valid_pct);
    logic [31:0] xr;
    logic [31:0] zr;
    for (int k = 0; k < len; k++) begin
      xr = $urandom;
      if (zspan == 0) begin
        zr = $urandom;
      end else begin
        zr = $urandom_range(0, 2 * zspan);
        zr = zr - zspan;
      end
      send_point(xr[COORD_BITS-1:0], zr[COORD_BITS-1:0],
                 $urandom_range(0, 99) < valid_pct, k == len - 1);
    end
  endtask

  // One random pass: profiles of random length, mostly long enough to reach the
  // median path, with a fresh half width before each profile.
  task automatic run_pass(input int src_pct, input int sink_pct, input int first_h);
    int sent;
    int h;
    int len;
    int zspan;
    int valid_pct;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    sent = 0;
    h    = first_h;
    while (sent < POINTS_PER_PASS) begin
      write_half(half_t'(h));
      if ($urandom_range(0, 3) == 0) len = $urandom_range(1, 2 * h + 1);
      else len = $urandom_range(2 * h + 1, 2 * h + 12);
      zspan     = $urandom_range(0, 1) ? 0 : 40;
      valid_pct = ($urandom_range(0, 7) == 0) ? 20 : 80;
      send_profile(len, zspan, valid_pct);
      sent += len;
      h = $urandom_range(0, MAX_HALF);
    end
  endtask

  initial begin
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_data        <= HALF_RESET;
    pts.valid       <= 1'b0;
    pts.x_in        <= '0;
    pts.z_in        <= '0;
    pts.valid_in    <= 1'b0;
    pts.profile_end <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part, starting at the reset half width of 2. The first profile puts
    // the coordinate extremes into the window; with the three middle points invalid
    // the windows hold two valid heights, so the mean of the middle pair is taken
    // for a negative odd sum (extremes give -1), a large negative sum and a small
    // positive odd sum, before an odd count and the flush of the last two points.
    send_point(X_MIN, X_MAX, 1'b1, 1'b0);
    send_point(X_MAX, X_MIN, 1'b1, 1'b0);
    send_point(-1, -1, 1'b0, 1'b0);
    send_point(0, 0, 1'b0, 1'b0);
    send_point(1, 1, 1'b0, 1'b0);
    send_point(12345, -3, 1'b1, 1'b0);
    send_point(-77, 8, 1'b1, 1'b0);
    send_point(X_MAX, 5, 1'b1, 1'b1);
    // A profile shorter than h+1 points: nothing comes out until its end.
    send_point(42, -42, 1'b1, 1'b1);
    // A profile shorter than 2h+1 points: every point passes unchanged.
    send_point(10, 100, 1'b1, 1'b0);
    send_point(11, -100, 1'b1, 1'b0);
    send_point(12, 7, 1'b0, 1'b0);
    send_point(13, 5, 1'b1, 1'b1);
    // Smallest useful half width with a window that holds no valid point.
    write_half(1);
    send_point(20, 300, 1'b0, 1'b0);
    send_point(21, -300, 1'b0, 1'b0);
    send_point(22, 9, 1'b0, 1'b1);
    // Half width zero: every point is emitted at once, unchanged.
    write_half(0);
    send_point(30, 6, 1'b1, 1'b0);
    send_point(31, 8, 1'b0, 1'b1);
    // Half width raised inside a profile, once the block has gone idle: the next
    // points reach back further into the window, so earlier points are repeated.
    write_half(1);
    send_point(40, 3, 1'b1, 1'b0);
    send_point(41, 1, 1'b1, 1'b0);
    send_point(42, 2, 1'b1, 1'b0);
    write_half(3);
    send_point(43, -4, 1'b1, 1'b0);
    send_point(44, 9, 1'b0, 1'b0);
    send_point(45, 0, 1'b1, 1'b1);

    // Back pressure at the widest window: the results side holds off for a long
    // stretch while points keep coming, so the block must stall its input.
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    write_half(half_t'(MAX_HALF));
    long_hold <= 1'b1;
    send_profile(24, 0, 90);

    // Random passes: sender light and receiver heavy, then the reverse, then no gaps.
    run_pass(30, 64, MAX_HALF);
    run_pass(64, 30, 1);
    run_pass(0, 0, $urandom_range(0, MAX_HALF));

    // Wait for the last results, then give the block time to show any extra output.
    pts.valid <= 1'b0;
    do @(posedge clk); while (pending_points != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
